### rtl/core/lvhk_pkg.sv
// Shared types and constants for the Langevin velocity half-kick block.
package lvhk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_TYPES = 4;
  localparam int TYPE_BITS = 2;
  localparam int TABLE_FRAC = 8;

  // Largest q whose (6*q) << FRAC_BITS still fits in 64 bits.
  localparam logic [63:0] Q_LIM = (64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS) / 64'd6;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [2:0] {
    REG_DELTA_T,
    REG_TEMPERATURE,
    REG_DRAG_SCALE,
    REG_USE_DIAMETER_DRAG,
    REG_NOISE_OFF,
    REG_TALLY_ON,
    REG_THREE_DIMS,
    REG_TYPE_DRAG_TABLE
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_G_MUL,
    OP_G_SET,
    OP_P_MUL,
    OP_Q_START,
    OP_DIV_STEP,
    OP_Q_FIN,
    OP_SQ_START,
    OP_SQ_STEP,
    OP_SQ_FIN,
    OP_N_MUL,
    OP_D_MUL,
    OP_BD,
    OP_NUM,
    OP_ACC,
    OP_AD_MUL,
    OP_NV,
    OP_BN_MUL,
    OP_E,
    OP_T_SUM,
    OP_MD_LO,
    OP_MD_HI,
    OP_MD_FIN,
    OP_R_APPLY,
    OP_L_APPLY
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       md_src;    // 0: step sum, 1: last half transfer
    logic       capture;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic noise_off;
    logic dt_zero;
    logic q_big;
    logic mass_zero;
    logic tally_on;
    logic step_end;
    logic div_last;
    logic sq_last;
  } stat_t;

endpackage

### rtl/core/lvhk_ctrl.sv
// Sequencer for the half-kick datapath.
module lvhk_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lvhk_pkg::stat_t  stat,
  output lvhk_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_G_MUL, S_G_SET, S_P_MUL, S_Q_START, S_Q_DIV, S_Q_FIN,
    S_SQ_START, S_SQ_RUN, S_SQ_FIN,
    S_N_MUL, S_D_MUL, S_BD, S_NUM, S_A_DIV, S_ACC, S_AD_MUL, S_NV, S_BN_MUL, S_E,
    S_T_SUM, S_R_LO, S_R_HI, S_R_FIN, S_R_APPLY,
    S_L_LO, S_L_HI, S_L_FIN, S_L_APPLY, S_DONE
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_G_MUL;
          axis  <= '0;
        end
        S_G_MUL:   state <= S_G_SET;
        S_G_SET:   state <= S_P_MUL;
        S_P_MUL:   state <= S_Q_START;
        S_Q_START: begin
          if (stat.noise_off)    state <= S_N_MUL;
          else if (stat.dt_zero) state <= S_SQ_START;
          else                   state <= S_Q_DIV;
        end
        S_Q_DIV:    if (stat.div_last) state <= S_Q_FIN;
        S_Q_FIN:    state <= S_SQ_START;
        S_SQ_START: state <= stat.q_big ? S_N_MUL : S_SQ_RUN;
        S_SQ_RUN:   if (stat.sq_last) state <= S_SQ_FIN;
        S_SQ_FIN:   state <= S_N_MUL;
        S_N_MUL:    state <= S_D_MUL;
        S_D_MUL:    state <= S_BD;
        S_BD:       state <= S_NUM;
        S_NUM:      state <= stat.mass_zero ? S_ACC : S_A_DIV;
        S_A_DIV:    if (stat.div_last) state <= S_ACC;
        S_ACC:      state <= S_AD_MUL;
        S_AD_MUL:   state <= S_NV;
        S_NV:       state <= S_BN_MUL;
        S_BN_MUL:   state <= S_E;
        S_E: begin
          if (axis == lvhk_pkg::LAST_AXIS) begin
            state <= S_T_SUM;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_N_MUL;
          end
        end
        S_T_SUM:   state <= (stat.step_end && stat.tally_on) ? S_R_LO : S_L_LO;
        S_R_LO:    state <= S_R_HI;
        S_R_HI:    state <= S_R_FIN;
        S_R_FIN:   state <= S_R_APPLY;
        S_R_APPLY: state <= S_L_LO;
        S_L_LO:    state <= S_L_HI;
        S_L_HI:    state <= S_L_FIN;
        S_L_FIN:   state <= S_L_APPLY;
        S_L_APPLY: state <= S_DONE;
        S_DONE: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.load_out = (state == S_DONE) && out_free;
    cmd.md_src   = (state == S_L_LO) || (state == S_L_HI) || (state == S_L_FIN);
    case (state)
      S_G_MUL:             cmd.op = lvhk_pkg::OP_G_MUL;
      S_G_SET:             cmd.op = lvhk_pkg::OP_G_SET;
      S_P_MUL:             cmd.op = lvhk_pkg::OP_P_MUL;
      S_Q_START:           cmd.op = lvhk_pkg::OP_Q_START;
      S_Q_DIV, S_A_DIV:    cmd.op = lvhk_pkg::OP_DIV_STEP;
      S_Q_FIN:             cmd.op = lvhk_pkg::OP_Q_FIN;
      S_SQ_START:          cmd.op = lvhk_pkg::OP_SQ_START;
      S_SQ_RUN:            cmd.op = lvhk_pkg::OP_SQ_STEP;
      S_SQ_FIN:            cmd.op = lvhk_pkg::OP_SQ_FIN;
      S_N_MUL:             cmd.op = lvhk_pkg::OP_N_MUL;
      S_D_MUL:             cmd.op = lvhk_pkg::OP_D_MUL;
      S_BD:                cmd.op = lvhk_pkg::OP_BD;
      S_NUM:               cmd.op = lvhk_pkg::OP_NUM;
      S_ACC:               cmd.op = lvhk_pkg::OP_ACC;
      S_AD_MUL:            cmd.op = lvhk_pkg::OP_AD_MUL;
      S_NV:                cmd.op = lvhk_pkg::OP_NV;
      S_BN_MUL:            cmd.op = lvhk_pkg::OP_BN_MUL;
      S_E:                 cmd.op = lvhk_pkg::OP_E;
      S_T_SUM:             cmd.op = lvhk_pkg::OP_T_SUM;
      S_R_LO, S_L_LO:      cmd.op = lvhk_pkg::OP_MD_LO;
      S_R_HI, S_L_HI:      cmd.op = lvhk_pkg::OP_MD_HI;
      S_R_FIN, S_L_FIN:    cmd.op = lvhk_pkg::OP_MD_FIN;
      S_R_APPLY:           cmd.op = lvhk_pkg::OP_R_APPLY;
      S_L_APPLY:           cmd.op = lvhk_pkg::OP_L_APPLY;
      default:             cmd.op = lvhk_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/core/lvhk_dp.sv
// Datapath: config registers, shared multiplier, divide/sqrt unit, energy tally.
module lvhk_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  lvhk_pkg::cmd_t      cmd,
  output lvhk_pkg::stat_t     stat,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  input  logic [31:0]         mass,
  input  logic signed [31:0]  force_x,
  input  logic signed [31:0]  force_y,
  input  logic signed [31:0]  force_z,
  input  logic [31:0]         diameter_or_type,
  input  logic signed [15:0]  rand_x,
  input  logic signed [15:0]  rand_y,
  input  logic signed [15:0]  rand_z,
  input  logic                step_end,
  output logic signed [31:0]  new_vel_x,
  output logic signed [31:0]  new_vel_y,
  output logic signed [31:0]  new_vel_z,
  output logic signed [31:0]  accel_x,
  output logic signed [31:0]  accel_y,
  output logic signed [31:0]  accel_z,
  output logic signed [63:0]  reservoir_energy,
  output logic signed [63:0]  logged_energy,
  output logic                step_done
);

  localparam int FB = lvhk_pkg::FRAC_BITS;

  // config
  logic [31:0] delta_t, temperature, drag_scale;
  logic        use_diameter_drag, noise_off, tally_on, three_dims;
  logic [63:0] type_drag_table;

  // item
  logic signed [31:0] vel [3];
  logic signed [31:0] frc [3];
  logic signed [15:0] rnd [3];
  logic [31:0]        mass_r, dia;
  logic               end_r;

  // working values
  logic [31:0]        gamma, coeff;
  logic [63:0]        q;
  logic signed [63:0] noise;
  logic signed [31:0] bd, acc_cur, nv_cur;
  logic signed [31:0] acc_keep [3];
  logic signed [31:0] nv_keep [3];
  logic               num_neg, num_zero;

  // divide / sqrt unit
  logic [63:0] dq;
  logic [31:0] rem, den;
  logic [5:0]  iter;
  logic [63:0] sq_x, sq_res, sq_bit;

  // energy
  logic signed [63:0] e_sum, step_sum, reservoir, last_half, mdt, logged;
  logic signed [96:0] md_acc;

  // multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  logic [1:0]          ax;
  logic signed [63:0]  md_src;
  logic [63:0]         g_sh;
  logic [15:0]         entry;
  logic signed [65:0]  bd_diff, nv_sum;
  logic signed [63:0]  num;
  logic [32:0]         div_t;
  logic                div_ge;
  logic [63:0]         sq_t, six_q;
  logic signed [31:0]  acc_new;
  logic signed [96:0]  md_tot;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v[65:31] != {35{v[65]}}) return v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [96:0] v);
    if (v[96:63] != {34{v[96]}})
      return v[96] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return v[63:0];
  endfunction

  assign ax     = cmd.axis;
  assign md_src = cmd.md_src ? last_half : step_sum;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      lvhk_pkg::OP_G_MUL:  begin ma = {1'b0, drag_scale}; mb = {1'b0, dia}; end
      lvhk_pkg::OP_P_MUL:  begin ma = {1'b0, gamma}; mb = {1'b0, temperature}; end
      lvhk_pkg::OP_N_MUL:  begin ma = 33'(rnd[ax]); mb = {1'b0, coeff}; end
      lvhk_pkg::OP_D_MUL:  begin ma = {1'b0, gamma}; mb = 33'(vel[ax]); end
      lvhk_pkg::OP_AD_MUL: begin ma = 33'(acc_cur); mb = {1'b0, delta_t}; end
      lvhk_pkg::OP_BN_MUL: begin ma = 33'(bd); mb = 33'(nv_cur); end
      lvhk_pkg::OP_MD_LO:  begin ma = {1'b0, md_src[31:0]}; mb = {1'b0, delta_t}; end
      lvhk_pkg::OP_MD_HI:  begin ma = {md_src[63], md_src[63:32]}; mb = {1'b0, delta_t}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) mp <= ma * mb;

  assign g_sh    = mp[63:0] >> FB;
  assign entry   = type_drag_table[dia[lvhk_pkg::TYPE_BITS-1:0]*16 +: 16];
  assign bd_diff = 66'(noise) - (mp >>> FB);
  assign nv_sum  = 66'(vel[ax]) + (mp >>> (FB + 1));
  assign num     = (64'(frc[ax]) + 64'(bd)) <<< FB;
  assign div_t   = {rem, dq[63]};
  assign div_ge  = div_t >= {1'b0, den};
  assign sq_t    = sq_res + sq_bit;
  assign six_q   = (q << 2) + (q << 1);
  assign md_tot  = md_acc + (97'(mp) <<< 32);

  always_comb begin
    if (mass_r == '0)
      acc_new = num_zero ? 32'sd0 : (num_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    else if (num_neg)
      acc_new = (dq > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dq[31:0]);
    else
      acc_new = (dq > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq[31:0];
  end

  always_comb begin
    stat.noise_off = noise_off;
    stat.dt_zero   = (delta_t == '0);
    stat.q_big     = (q > lvhk_pkg::Q_LIM);
    stat.mass_zero = (mass_r == '0);
    stat.tally_on  = tally_on;
    stat.step_end  = end_r;
    stat.div_last  = (iter == 6'd63);
    stat.sq_last   = (iter == 6'd31);
  end

  // config and energy state
  always_ff @(posedge clk) begin
    if (rst) begin
      delta_t           <= 32'd328;
      temperature       <= 32'd65536;
      drag_scale        <= 32'd65536;
      use_diameter_drag <= 1'b1;
      noise_off         <= 1'b0;
      tally_on          <= 1'b0;
      three_dims        <= 1'b1;
      type_drag_table   <= 64'h0100_0100_0100_0100;
      step_sum          <= '0;
      reservoir         <= '0;
      last_half         <= '0;
    end else begin
      if (cfg_we) begin
        case (lvhk_pkg::reg_idx_t'(cfg_index))
          lvhk_pkg::REG_DELTA_T:           delta_t           <= cfg_data[31:0];
          lvhk_pkg::REG_TEMPERATURE:       temperature       <= cfg_data[31:0];
          lvhk_pkg::REG_DRAG_SCALE:        drag_scale        <= cfg_data[31:0];
          lvhk_pkg::REG_USE_DIAMETER_DRAG: use_diameter_drag <= cfg_data[0];
          lvhk_pkg::REG_NOISE_OFF:         noise_off         <= cfg_data[0];
          lvhk_pkg::REG_TALLY_ON:          tally_on          <= cfg_data[0];
          lvhk_pkg::REG_THREE_DIMS:        three_dims        <= cfg_data[0];
          lvhk_pkg::REG_TYPE_DRAG_TABLE:   type_drag_table   <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        lvhk_pkg::OP_T_SUM: begin
          if (tally_on) step_sum <= sat64(97'(65'(step_sum) + 65'(e_sum)));
          else if (end_r) step_sum <= '0;
        end
        lvhk_pkg::OP_R_APPLY: begin
          reservoir <= sat64(97'(65'(reservoir) - 65'(mdt)));
          last_half <= step_sum >>> 1;
          step_sum  <= '0;
        end
        default: ;
      endcase
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vel[0] <= vel_x;   vel[1] <= vel_y;   vel[2] <= vel_z;
      frc[0] <= force_x; frc[1] <= force_y; frc[2] <= force_z;
      rnd[0] <= rand_x;  rnd[1] <= rand_y;  rnd[2] <= rand_z;
      mass_r <= mass;
      dia    <= diameter_or_type;
      end_r  <= step_end;
      e_sum  <= '0;
    end
    case (cmd.op)
      lvhk_pkg::OP_G_SET: begin
        if (use_diameter_drag)
          gamma <= (g_sh[63:32] != '0) ? '1 : g_sh[31:0];
        else if (dia < 32'(lvhk_pkg::NUM_TYPES))
          gamma <= 32'(entry) << (FB - lvhk_pkg::TABLE_FRAC);
        else
          gamma <= '0;
      end
      lvhk_pkg::OP_Q_START: begin
        if (noise_off) coeff <= '0;
        q    <= (mp[63:0] == '0) ? '0 : '1;
        dq   <= mp[63:0];
        rem  <= '0;
        den  <= delta_t;
        iter <= '0;
      end
      lvhk_pkg::OP_DIV_STEP: begin
        rem  <= div_ge ? 32'(div_t - {1'b0, den}) : div_t[31:0];
        dq   <= {dq[62:0], div_ge};
        iter <= iter + 6'd1;
      end
      lvhk_pkg::OP_Q_FIN: q <= dq;
      lvhk_pkg::OP_SQ_START: begin
        if (stat.q_big) coeff <= '1;
        sq_x   <= six_q << FB;
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        iter   <= '0;
      end
      lvhk_pkg::OP_SQ_STEP: begin
        if (sq_x >= sq_t) begin
          sq_x   <= sq_x - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        iter   <= iter + 6'd1;
      end
      lvhk_pkg::OP_SQ_FIN: coeff <= sq_res[31:0];
      lvhk_pkg::OP_D_MUL:  noise <= 64'(mp >>> 15);
      lvhk_pkg::OP_BD:
        bd <= (ax == lvhk_pkg::LAST_AXIS && !three_dims) ? 32'sd0 : sat32(bd_diff);
      lvhk_pkg::OP_NUM: begin
        num_neg  <= num[63];
        num_zero <= (num == '0);
        dq       <= num[63] ? (64'(-num) + {32'b0, mass_r} - 64'd1) : num;
        rem      <= '0;
        den      <= mass_r;
        iter     <= '0;
      end
      lvhk_pkg::OP_ACC: begin
        acc_cur      <= acc_new;
        acc_keep[ax] <= acc_new;
      end
      lvhk_pkg::OP_NV: begin
        nv_cur      <= sat32(nv_sum);
        nv_keep[ax] <= sat32(nv_sum);
      end
      lvhk_pkg::OP_E:      e_sum  <= sat64(97'(mp) + 97'(e_sum));
      lvhk_pkg::OP_MD_HI:  md_acc <= 97'(mp);
      lvhk_pkg::OP_MD_FIN: mdt    <= sat64(md_tot >>> FB);
      lvhk_pkg::OP_L_APPLY: logged <= sat64(97'(65'(reservoir) + 65'(mdt)));
      default: ;
    endcase
    if (cmd.load_out) begin
      new_vel_x        <= nv_keep[0];
      new_vel_y        <= nv_keep[1];
      new_vel_z        <= nv_keep[2];
      accel_x          <= acc_keep[0];
      accel_y          <= acc_keep[1];
      accel_z          <= acc_keep[2];
      reservoir_energy <= reservoir;
      logged_energy    <= logged;
      step_done        <= end_r;
    end
  end

endmodule

### rtl/core/langevin_velocity_half_kick.sv
// Top level of the Langevin thermostat velocity half-kick block.
//
//   channel  direction  handshake             carries
//   cfg      in         cfg_we                cfg_index, cfg_data (write only)
//   in       in         in_valid / in_ready   one particle per beat
//   out      out        out_valid / out_ready one kicked particle per beat
//
// With noise on, each beat runs a bit-serial divide of drag times temperature
// by dt, a square root, three divides by mass and one multiplier shared by all
// products; a tallied step that closes adds the reservoir update. Noise off
// skips the divide and square root; zero mass skips that axis's divide.
// Reset clears the energy tally, restores register defaults, empties output.
// A result waiting on out_ready does not block the next input beat; a second
// finished result waits in the last sequencer state until the first is taken.
module langevin_velocity_half_kick (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [31:0]        mass,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic [31:0]        diameter_or_type,
  input  logic signed [15:0] rand_x,
  input  logic signed [15:0] rand_y,
  input  logic signed [15:0] rand_z,
  input  logic               step_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z,
  output logic signed [63:0] reservoir_energy,
  output logic signed [63:0] logged_energy,
  output logic               step_done
);

  lvhk_pkg::cmd_t  cmd;
  lvhk_pkg::stat_t stat;

  // Sequencer: walks drag, noise amplitude, then x/y/z kicks, then the tally.
  lvhk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: holds the registers, the item, the shared multiplier and the
  // bit-serial divide / square root unit, plus the output register.
  lvhk_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .vel_x            (vel_x),
    .vel_y            (vel_y),
    .vel_z            (vel_z),
    .mass             (mass),
    .force_x          (force_x),
    .force_y          (force_y),
    .force_z          (force_z),
    .diameter_or_type (diameter_or_type),
    .rand_x           (rand_x),
    .rand_y           (rand_y),
    .rand_z           (rand_z),
    .step_end         (step_end),
    .new_vel_x        (new_vel_x),
    .new_vel_y        (new_vel_y),
    .new_vel_z        (new_vel_z),
    .accel_x          (accel_x),
    .accel_y          (accel_y),
    .accel_z          (accel_z),
    .reservoir_energy (reservoir_energy),
    .logged_energy    (logged_energy),
    .step_done        (step_done)
  );

`ifndef SYNTH
  // An accepted beat starts a multi-cycle run: no second beat next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accepted beat");

  // Posting a result returns the sequencer to idle in the same edge.
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result posted without returning to idle");
`endif

endmodule
